/* rtl/core/segment_circle_hit_test_assert.svh */
// ----------------------------------------------------------------------------
// segment_circle_hit_test assertion macros
// shared concurrent assertion forms for the hit test rtl
// ----------------------------------------------------------------------------
`ifndef SEGMENT_CIRCLE_HIT_TEST_ASSERT_SVH
`define SEGMENT_CIRCLE_HIT_TEST_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SCHIT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hit test assertion failed");

// implication after a fixed number of cycles, disabled while in reset
`define SCHIT_ASSERT_DELAY(lbl, clk, rst, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("hit test delayed assertion failed");

`endif

/* rtl/core/schit_pkg.sv */
// ----------------------------------------------------------------------------
// schit_pkg
// shared types and constants of the segment circle hit test
// ----------------------------------------------------------------------------
package schit_pkg;

  // radius scale register, unsigned q8.8
  localparam int unsigned SCALE_W          = 16;
  localparam int unsigned SCALE_FRAC       = 8;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

  // term widths
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned DIFF_W   = COORD_W + 1;
  localparam int unsigned RAD_W    = 12;
  localparam int unsigned R_W      = RAD_W + SCALE_W - SCALE_FRAC;
  localparam int unsigned SQ_W     = 2 * DIFF_W;
  localparam int unsigned A_W      = SQ_W;
  localparam int unsigned H_W      = SQ_W + 1;
  localparam int unsigned RR_W     = 2 * R_W;
  localparam int unsigned C_W      = RR_W + 2;
  localparam int unsigned PROD_W   = 2 * A_W;

  // cycles from an accepted beat to its result strobe
  localparam int unsigned LATENCY  = 6;

  // quadratic terms handed from the geometry stages to the decision stages
  typedef struct packed {
    logic                    valid;
    logic [A_W-1:0]          a;
    logic signed [H_W-1:0]   h;
    logic [A_W-1:0]          ff;
    logic [RR_W-1:0]         rr;
  } terms_t;

endpackage

/* rtl/core/segment_circle_hit_test.sv */
// ----------------------------------------------------------------------------
// segment_circle_hit_test
// exact integer test of a segment against a scaled circle
// ----------------------------------------------------------------------------
// usage:
//   a test beat is taken at a rising edge with start high and busy low;
//   busy stays low, so one beat can be taken in every cycle.
//   the beat carries the segment ends, the circle centre and the raw radius.
//   the result is shown on hit for one cycle with done high, after its beat
//   has passed the pipeline, in the order the beats came in.
//   the six register stages (differences, squares, sums, c, wide products,
//   decision) lie between beat and result; throughput is one test per cycle.
//   the receiver cannot hold results off, so nothing stalls the pipeline.
//   cfg_we writes cfg_wdata to the q8.8 radius scale; the user is to write
//   it only while no test is in flight, which the block does not enforce.
//   reset clears the valid bits and done, and sets the scale to one.
// ----------------------------------------------------------------------------
`include "segment_circle_hit_test_assert.svh"

module segment_circle_hit_test
  import schit_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [SCALE_W-1:0]        cfg_wdata,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] seg_start_x,
  input  logic signed [COORD_W-1:0] seg_start_y,
  input  logic signed [COORD_W-1:0] seg_end_x,
  input  logic signed [COORD_W-1:0] seg_end_y,
  input  logic signed [COORD_W-1:0] center_x,
  input  logic signed [COORD_W-1:0] center_y,
  input  logic [RAD_W-1:0]          obstacle_radius,
  output logic                      done,
  output logic                      hit
);

  logic [SCALE_W-1:0]         rad_scale;
  logic                       accept;
  logic [RAD_W+SCALE_W-1:0]   r_prod;
  logic                       zero_len;

  // stage 1
  logic                       valid1;
  logic signed [DIFF_W-1:0]   dx1;
  logic signed [DIFF_W-1:0]   dy1;
  logic signed [DIFF_W-1:0]   fx1;
  logic signed [DIFF_W-1:0]   fy1;
  logic [R_W-1:0]             r1;

  // stage 2
  logic                       valid2;
  logic signed [SQ_W-1:0]     dxx2;
  logic signed [SQ_W-1:0]     dyy2;
  logic signed [SQ_W-1:0]     fxdx2;
  logic signed [SQ_W-1:0]     fydy2;
  logic signed [SQ_W-1:0]     fxx2;
  logic signed [SQ_W-1:0]     fyy2;
  logic [RR_W-1:0]            rr2;

  // stage 3
  logic signed [SQ_W:0]       a_sum;
  logic signed [SQ_W:0]       ff_sum;
  terms_t                     terms;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // radius scale register
  always_ff @(posedge clk) begin
    if (rst) begin
      rad_scale <= SCALE_RESET;
    end else if (cfg_we) begin
      rad_scale <= cfg_wdata;
    end
  end

  // valid bits of the geometry stages
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
    end else begin
      valid1 <= accept;
      valid2 <= valid1;
    end
  end

  // scaled radius, truncated to whole millimetres
  assign r_prod = obstacle_radius * rad_scale;

  // stage 1: direction d = q - p, offset f = p - c
  always_ff @(posedge clk) begin
    dx1 <= DIFF_W'(seg_end_x) - DIFF_W'(seg_start_x);
    dy1 <= DIFF_W'(seg_end_y) - DIFF_W'(seg_start_y);
    fx1 <= DIFF_W'(seg_start_x) - DIFF_W'(center_x);
    fy1 <= DIFF_W'(seg_start_y) - DIFF_W'(center_y);
    r1  <= r_prod[RAD_W+SCALE_W-1:SCALE_FRAC];
  end

  // stage 2: component products
  always_ff @(posedge clk) begin
    dxx2  <= dx1 * dx1;
    dyy2  <= dy1 * dy1;
    fxdx2 <= fx1 * dx1;
    fydy2 <= fy1 * dy1;
    fxx2  <= fx1 * fx1;
    fyy2  <= fy1 * fy1;
    rr2   <= r1 * r1;
  end

  // stage 3: dot products
  assign a_sum  = (SQ_W+1)'(dxx2) + (SQ_W+1)'(dyy2);
  assign ff_sum = (SQ_W+1)'(fxx2) + (SQ_W+1)'(fyy2);

  always_ff @(posedge clk) begin
    if (rst) begin
      terms.valid <= 1'b0;
    end else begin
      terms.valid <= valid2;
    end
    terms.a  <= a_sum[A_W-1:0];
    terms.h  <= (SQ_W+1)'(fxdx2) + (SQ_W+1)'(fydy2);
    terms.ff <= ff_sum[A_W-1:0];
    terms.rr <= rr2;
  end

  // stages 4 to 6: discriminant sign and root bounds
  schit_decide u_decide (
    .clk   (clk),
    .rst   (rst),
    .terms (terms),
    .done  (done),
    .hit   (hit)
  );

  // segment of zero length on the input
  assign zero_len = (seg_start_x == seg_end_x) && (seg_start_y == seg_end_y);

  // every taken beat gives a strobe after the pipeline latency
  `SCHIT_ASSERT_DELAY(a_beat_gives_done, clk, rst, accept, LATENCY, done)
  // no strobe without a beat taken that many cycles before
  `SCHIT_ASSERT_IMPL(a_done_has_beat, clk, rst, done, $past(accept, LATENCY))
  // hit is only raised inside a strobe
  `SCHIT_ASSERT_IMPL(a_hit_in_done, clk, rst, hit, done)
  // a segment of zero length never hits
  `SCHIT_ASSERT_DELAY(a_point_no_hit, clk, rst, accept && zero_len, LATENCY, !hit)

endmodule

/* rtl/core/schit_decide.sv */
// ----------------------------------------------------------------------------
// schit_decide
// decides from a, h, f.f and r^2 whether a root of the quadratic is in [0,1]
// ----------------------------------------------------------------------------
module schit_decide
  import schit_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  terms_t terms,
  output logic   done,
  output logic   hit
);

  // stage 4: c, a + h
  logic                  valid4;
  logic                  a_nz4;
  logic [A_W-1:0]        a4;
  logic signed [H_W-1:0] h4;
  logic signed [C_W-1:0] c4;
  logic signed [H_W:0]   ah4;

  // stage 5: e = a + 2h + c, squares for the discriminant sign
  logic                  valid5;
  logic                  a_nz5;
  logic                  h_le0_5;
  logic                  ah_ge0_5;
  logic                  c_ge0_5;
  logic                  c_le0_5;
  logic signed [C_W+1:0] e5;
  logic [PROD_W-1:0]     hh5;
  logic [PROD_W-1:0]     ac5;

  logic signed [H_W-1:0] habs_full;
  logic [A_W-1:0]        habs;
  logic                  disc_ok;
  logic                  e_le0;
  logic                  e_ge0;
  logic                  t1;
  logic                  t2;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid4 <= 1'b0;
      valid5 <= 1'b0;
      done   <= 1'b0;
    end else begin
      valid4 <= terms.valid;
      valid5 <= valid4;
      done   <= valid5;
    end
  end

  // stage 4 datapath
  always_ff @(posedge clk) begin
    a4    <= terms.a;
    h4    <= terms.h;
    a_nz4 <= (terms.a != '0);
    c4    <= $signed({{(C_W-A_W){1'b0}}, terms.ff}) - $signed({2'b00, terms.rr});
    ah4   <= $signed({2'b00, terms.a}) + (H_W+1)'(terms.h);
  end

  // magnitude of h, which never exceeds the width of a
  assign habs_full = h4[H_W-1] ? -h4 : h4;
  assign habs      = habs_full[A_W-1:0];

  // stage 5 datapath; c only matters in the product when positive,
  // and then it is no larger than f.f
  always_ff @(posedge clk) begin
    a_nz5    <= a_nz4;
    h_le0_5  <= h4[H_W-1] || (h4 == '0);
    ah_ge0_5 <= !ah4[H_W];
    c_ge0_5  <= !c4[C_W-1];
    c_le0_5  <= c4[C_W-1] || (c4 == '0);
    e5       <= (C_W+2)'(ah4) + (C_W+2)'(h4) + (C_W+2)'(c4);
    hh5      <= habs * habs;
    ac5      <= a4 * c4[A_W-1:0];
  end

  // root bounds worked out as signs of a, h, c and e
  assign disc_ok = c_le0_5 || (hh5 >= ac5);
  assign e_le0   = e5[C_W+1] || (e5 == '0);
  assign e_ge0   = !e5[C_W+1];
  assign t1      = (ah_ge0_5 || e_le0) && h_le0_5 && c_ge0_5;
  assign t2      = (h_le0_5 || c_le0_5) && ah_ge0_5 && e_ge0;

  // stage 6: result register, low outside a strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else begin
      hit <= valid5 && a_nz5 && disc_ok && (t1 || t2);
    end
  end

endmodule

/* verif/tb_segment_circle_hit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_circle_hit_test
// self-checking bench for the segment against scaled circle hit test
// ----------------------------------------------------------------------------
// a queue of test beats is filled phase by phase and a clocked driver
// presents them with random sender gaps. every accepted beat is scored by
// an exact 128-bit integer predictor and the expected hit is queued. the
// monitor pops one expectation per done strobe and compares. the radius
// scale is rewritten between phases, once all results are back.
// ----------------------------------------------------------------------------
module tb_segment_circle_hit_test;
  import schit_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [RAD_W-1:0]          rad;
  } seg_beat_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [SCALE_W-1:0]        cfg_wdata = '0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [COORD_W-1:0] seg_start_x = '0;
  logic signed [COORD_W-1:0] seg_start_y = '0;
  logic signed [COORD_W-1:0] seg_end_x = '0;
  logic signed [COORD_W-1:0] seg_end_y = '0;
  logic signed [COORD_W-1:0] center_x = '0;
  logic signed [COORD_W-1:0] center_y = '0;
  logic [RAD_W-1:0]          obstacle_radius = '0;
  logic                      done;
  logic                      hit;

  seg_beat_t          pending_beats[$];
  bit                 hit_expected[$];
  logic [SCALE_W-1:0] scale_model = SCALE_RESET;
  int                 sender_idle_pct = 0;
  int                 fail_count = 0;
  logic               beat_taken = 1'b0;

  segment_circle_hit_test dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .start           (start),
    .busy            (busy),
    .seg_start_x     (seg_start_x),
    .seg_start_y     (seg_start_y),
    .seg_end_x       (seg_end_x),
    .seg_end_y       (seg_end_y),
    .center_x        (center_x),
    .center_y        (center_y),
    .obstacle_radius (obstacle_radius),
    .done            (done),
    .hit             (hit)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // sqrt(disc) <= v, disc known non-negative
  function automatic bit root_at_most(logic signed [127:0] disc, longint v);
    logic signed [127:0] vw;
    vw = v;
    if (v < 0) return 1'b0;
    return (vw * vw >= disc);
  endfunction

  // sqrt(disc) >= v, disc known non-negative
  function automatic bit root_at_least(logic signed [127:0] disc, longint v);
    logic signed [127:0] vw;
    vw = v;
    if (v <= 0) return 1'b1;
    return (disc >= vw * vw);
  endfunction

  function automatic longint scaled_radius(logic [RAD_W-1:0] rad, logic [SCALE_W-1:0] scale);
    longint rl, sl;
    rl = rad;
    sl = scale;
    return (rl * sl) >>> SCALE_FRAC;
  endfunction

  // exact quadratic test: a = d.d, h = f.d, c = f.f - r^2, disc = h^2 - a*c
  function automatic bit predict_hit(seg_beat_t b, logic [SCALE_W-1:0] scale);
    longint px, py, qx, qy, ccx, ccy, r, dx, dy, fx, fy, a, h, c, m;
    logic signed [127:0] hw, aw, cw, disc;
    bit near_root, far_root;
    px = b.sx;
    py = b.sy;
    qx = b.ex;
    qy = b.ey;
    ccx = b.cx;
    ccy = b.cy;
    r = scaled_radius(b.rad, scale);
    dx = qx - px;
    dy = qy - py;
    fx = px - ccx;
    fy = py - ccy;
    a = dx * dx + dy * dy;
    h = fx * dx + fy * dy;
    c = fx * fx + fy * fy - r * r;
    // degenerate segment never hits
    if (a == 0) return 1'b0;
    hw = h;
    aw = a;
    cw = c;
    disc = hw * hw - aw * cw;
    if (disc < 0) return 1'b0;
    m = -h;
    near_root = root_at_least(disc, m - a) && root_at_most(disc, m);
    far_root  = root_at_least(disc, -m) && root_at_most(disc, a - m);
    return near_root || far_root;
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [COORD_W-1:0] extreme_coord();
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'sh0001;
    endcase
  endfunction

  // random beat, mostly shaped around the circle so that hits are common
  function automatic seg_beat_t make_beat(logic [SCALE_W-1:0] scale);
    seg_beat_t b;
    int ccx, ccy, r, span, px, py;
    b.rad = RAD_W'($urandom);
    ccx = jitter(20000);
    ccy = jitter(20000);
    r = int'(scaled_radius(b.rad, scale));
    span = 2 * r + 16;
    b.cx = COORD_W'(ccx);
    b.cy = COORD_W'(ccy);
    case ($urandom_range(0, 9))
      0, 1: begin
        b.sx = COORD_W'($urandom);
        b.sy = COORD_W'($urandom);
        b.ex = COORD_W'($urandom);
        b.ey = COORD_W'($urandom);
        b.cx = COORD_W'($urandom);
        b.cy = COORD_W'($urandom);
      end
      5: begin
        // one end lying on the circle
        px = ccx;
        py = ccy;
        case ($urandom_range(0, 3))
          0: px = ccx + r;
          1: px = ccx - r;
          2: py = ccy + r;
          default: py = ccy - r;
        endcase
        b.sx = COORD_W'(px);
        b.sy = COORD_W'(py);
        b.ex = COORD_W'(px + jitter(span));
        b.ey = COORD_W'(py + jitter(span));
        if ($urandom_range(0, 1)) begin
          b.ex = b.sx;
          b.ey = b.sy;
          b.sx = COORD_W'(px + jitter(span));
          b.sy = COORD_W'(py + jitter(span));
        end
      end
      6: begin
        // zero-length segment
        b.sx = COORD_W'(ccx + jitter(span));
        b.sy = COORD_W'(ccy + jitter(span));
        b.ex = b.sx;
        b.ey = b.sy;
      end
      7: begin
        // both ends inside the circle
        b.sx = COORD_W'(ccx + jitter(r / 2));
        b.sy = COORD_W'(ccy + jitter(r / 2));
        b.ex = COORD_W'(ccx + jitter(r / 2));
        b.ey = COORD_W'(ccy + jitter(r / 2));
      end
      8: begin
        // tangent line, horizontal or vertical
        if ($urandom_range(0, 1)) begin
          b.sx = COORD_W'(ccx + jitter(span));
          b.ex = COORD_W'(ccx + jitter(span));
          b.sy = COORD_W'(ccy + r);
          b.ey = COORD_W'(ccy + r);
        end else begin
          b.sy = COORD_W'(ccy + jitter(span));
          b.ey = COORD_W'(ccy + jitter(span));
          b.sx = COORD_W'(ccx - r);
          b.ex = COORD_W'(ccx - r);
        end
      end
      9: begin
        b.sx = extreme_coord();
        b.sy = extreme_coord();
        b.ex = extreme_coord();
        b.ey = extreme_coord();
        b.cx = extreme_coord();
        b.cy = extreme_coord();
        b.rad = $urandom_range(0, 1) ? '1 : '0;
      end
      default: begin
        b.sx = COORD_W'(ccx + jitter(span));
        b.sy = COORD_W'(ccy + jitter(span));
        b.ex = COORD_W'(ccx + jitter(span));
        b.ey = COORD_W'(ccy + jitter(span));
      end
    endcase
    return b;
  endfunction

  task automatic add_beat(int sx, int sy, int ex, int ey, int cx, int cy, int rad);
    seg_beat_t b;
    b.sx = COORD_W'(sx);
    b.sy = COORD_W'(sy);
    b.ex = COORD_W'(ex);
    b.ey = COORD_W'(ey);
    b.cx = COORD_W'(cx);
    b.cy = COORD_W'(cy);
    b.rad = RAD_W'(rad);
    pending_beats.insert(pending_beats.size(), b);
  endtask

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // wait until every queued beat is taken and every result is back
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_beats.size() != 0 || start || hit_expected.size() != 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_scale(logic [SCALE_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    scale_model = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // driver: one beat per cycle at most, random sender gaps
  always @(negedge clk) begin : drive_proc
    seg_beat_t nxt;
    bit go;
    if (!rst && !(start && !beat_taken)) begin
      go = pending_beats.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct;
      if (go) begin
        nxt = pending_beats.pop_front();
        seg_start_x <= nxt.sx;
        seg_start_y <= nxt.sy;
        seg_end_x <= nxt.ex;
        seg_end_y <= nxt.ey;
        center_x <= nxt.cx;
        center_y <= nxt.cy;
        obstacle_radius <= nxt.rad;
      end
      start <= go;
    end
  end

  // monitor: score accepted beats and check each result strobe
  always @(posedge clk) begin : watch_proc
    seg_beat_t b;
    bit want;
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= start && !busy;
      if (done) begin
        if (hit_expected.size() == 0) begin
          note_failure($sformatf("result with nothing expected, hit=%0b", hit));
        end else begin
          want = hit_expected.pop_front();
          if (hit !== want)
            note_failure($sformatf("hit mismatch: expected %0b actual %0b", want, hit));
        end
      end
      if (start && !busy) begin
        b.sx = seg_start_x;
        b.sy = seg_start_y;
        b.ex = seg_end_x;
        b.ey = seg_end_y;
        b.cx = center_x;
        b.cy = center_y;
        b.rad = obstacle_radius;
        hit_expected.insert(hit_expected.size(), predict_hit(b, scale_model));
      end
    end
  end

  // stimulus and phase control
  initial begin : main_proc
    logic [SCALE_W-1:0] phase_scale[7];
    int phase_idle[7];
    phase_scale = '{16'hffff, 16'h0000, 16'h0100, 16'h0001, 16'h0000, 16'h0180, 16'h0000};
    phase_scale[4] = SCALE_W'($urandom);
    phase_scale[6] = SCALE_W'($urandom);
    phase_idle = '{8, 8, 8, 72, 72, 0, 0};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed beats at the reset scale
    sender_idle_pct = 8;
    add_beat(-32768, -32768, 32767, 32767, 0, 0, 4095);
    add_beat(-32768, -32768, 32767, 32767, 32767, -32768, 4095);
    add_beat(32767, 32767, 32767, 32767, 32767, 32767, 4095);
    add_beat(-32768, -32768, -32768, -32768, -32768, -32768, 0);
    add_beat(-32768, 32767, 32767, -32768, -32768, -32768, 0);
    add_beat(10, 10, 10, 10, 0, 0, 100);
    add_beat(-200, 100, 200, 100, 0, 0, 100);
    add_beat(-200, 101, 200, 101, 0, 0, 100);
    add_beat(100, 0, 200, 0, 0, 0, 100);
    add_beat(300, 0, 100, 0, 0, 0, 100);
    add_beat(-10, 5, 10, -5, 0, 0, 100);
    add_beat(0, 0, 10, 0, 5, 0, 0);
    add_beat(0, 0, 10, 0, 5, 1, 0);
    add_beat(0, 0, 10, 0, 10, 0, 0);
    add_beat(1000, 1000, 2000, 2000, -1000, 1000, 500);
    add_beat(-5000, 0, 5000, 0, 0, 0, 4095);
    add_beat(0, 4095, 1, 4095, 0, 0, 4095);
    add_beat(32767, -32768, -32768, 32767, 1, -1, 1);
    wait_drained();

    // random phases, each at its own scale and sender gap rate
    for (int p = 0; p < 7; p++) begin
      write_scale(phase_scale[p]);
      sender_idle_pct = phase_idle[p];
      for (int i = 0; i < 190; i++)
        pending_beats.insert(pending_beats.size(), make_beat(scale_model));
      wait_drained();
    end

    repeat (LATENCY + 4) @(posedge clk);
    #1;
    if (hit_expected.size() != 0)
      note_failure($sformatf("%0d results never arrived", hit_expected.size()));
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run time limit
  initial begin : limit_proc
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
